// ===== src/afce_pkg.sv =====
// Shared types and constants for the ADC frame channel extremes block.
// Holds configuration codes, reset values and the fixed-point volts constants.
// No dependencies.
package afce_pkg;

  // Default sample width.
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 1'd1;

  localparam logic [7:0]  CHANNEL_ID_RST = 8'd234;
  localparam logic [11:0] MAX_FRAME_RST  = 12'd1500;

  localparam logic [31:0] SYNC_WORD = 32'hFFFF_FFFF;

  // Result field widths.
  localparam int RAW_W   = 24;
  localparam int VOLTS_W = 21;
  localparam int MAX_W   = 23;
  localparam int MIN_W   = 24;

  // Volts conversion: q = round(|s| * 1024 / 9375), done as a reciprocal
  // multiply with one correction step. Magnitudes above the clamp saturate
  // anyway, so they are clipped first to keep the datapath narrow.
  localparam int MAG_W       = 24;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 40;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int SUM_W       = PROD_W + 10;
  localparam int Y_W         = MAG_W + 10;
  localparam int REM_W       = Y_W + 1;
  localparam int Q_W         = 21;

  localparam logic [MAG_W-1:0]   VOLT_CLAMP = 24'd9700000;
  localparam logic [RECIP_W-1:0] RECIP      = 27'd117281240;
  localparam logic [13:0]        ROUND_BIAS = 14'd4687;
  localparam logic [13:0]        VOLT_DIV   = 14'd9375;
  localparam logic [SUM_W-1:0]   ROUND_TERM = SUM_W'(ROUND_BIAS) * SUM_W'(RECIP);

  localparam logic [Q_W-1:0] VOLTS_POS_MAX = 21'd1048575;
  localparam logic [Q_W-1:0] VOLTS_NEG_MAG = 21'd1048576;

  // Control from the parser to the extremes tracker.
  typedef struct packed {
    logic clear;
    logic update;
  } afce_track_ctl_t;

endpackage

// ===== src/afce_in_if.sv =====
// Input word channel: valid/ready handshake with a command bit and a stream word.
// No dependencies.
interface afce_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] data_word;

  modport source (output valid, command, data_word, input ready);
  modport sink   (input valid, command, data_word, output ready);
endinterface

// ===== src/afce_out_if.sv =====
// Result word channel: valid/ready handshake with the sample, volts and extremes.
// No dependencies.
interface afce_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_raw;
  logic signed [20:0] sample_volts_q16;
  logic        [22:0] max_first;
  logic        [22:0] max_second;
  logic signed [23:0] min_first;
  logic signed [23:0] min_second;

  modport source (output valid, sample_raw, sample_volts_q16, max_first, max_second,
                  min_first, min_second, input ready);
  modport sink   (input valid, sample_raw, sample_volts_q16, max_first, max_second,
                  min_first, min_second, output ready);
endinterface

// ===== src/afce_frame_parser.sv =====
// Frame parser: sync, header and byte count, then the payload word countdown.
// Depends on afce_pkg.
module afce_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire_i,
  input  logic        command_i,
  input  logic [31:0] data_word_i,
  input  logic [7:0]  channel_id_i,
  input  logic [11:0] max_frame_i,
  output logic        hit_o
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_COUNT   = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [9:0] words_left_r, words_left_nxt;
  logic [9:0] wl_dec;

  always_comb begin
    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    wl_dec         = (words_left_r != 10'd0) ? words_left_r - 10'd1 : words_left_r;
    if (command_i) begin
      phase_nxt      = PH_HUNT;
      words_left_nxt = 10'd0;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (data_word_i == afce_pkg::SYNC_WORD) phase_nxt = PH_HEADER;
        end
        PH_HEADER: begin
          phase_nxt = data_word_i[31] ? PH_HUNT : PH_COUNT;
        end
        PH_COUNT: begin
          // Oversized frames and counts under one word go straight back to hunting.
          if (data_word_i > 32'(max_frame_i) || data_word_i[31:2] == 30'd0) begin
            phase_nxt      = PH_HUNT;
            words_left_nxt = 10'd0;
          end else begin
            phase_nxt      = PH_PAYLOAD;
            words_left_nxt = data_word_i[11:2];
          end
        end
        PH_PAYLOAD: begin
          words_left_nxt = wl_dec;
          if (wl_dec == 10'd0) phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      words_left_r <= 10'd0;
    end else if (fire_i) begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
    end
  end

  assign hit_o = !command_i && (phase_r == PH_PAYLOAD) &&
                 (data_word_i[31:24] == channel_id_i);

endmodule

// ===== src/afce_extremes.sv =====
// Running distinct first and second maxima and minima of the selected samples.
// Depends on afce_pkg for the control struct.
module afce_extremes #(
  parameter int SAMPLE_BITS = afce_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  afce_pkg::afce_track_ctl_t     ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic [4*SAMPLE_BITS-1:0]      ext_o
);

  logic signed [SAMPLE_BITS-1:0] max1_r, max2_r, min1_r, min2_r;
  logic signed [SAMPLE_BITS-1:0] max1_nxt, max2_nxt, min1_nxt, min2_nxt;

  always_comb begin
    max1_nxt = max1_r;
    max2_nxt = max2_r;
    min1_nxt = min1_r;
    min2_nxt = min2_r;
    if (sample_i > max1_r) begin
      max2_nxt = max1_r;
      max1_nxt = sample_i;
    end else if (sample_i < max1_r && sample_i > max2_r) begin
      max2_nxt = sample_i;
    end
    if (sample_i < min1_r) begin
      min2_nxt = min1_r;
      min1_nxt = sample_i;
    end else if (sample_i > min1_r && sample_i < min2_r) begin
      min2_nxt = sample_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl_i.clear) begin
      max1_r <= '0;
      max2_r <= '0;
      min1_r <= '0;
      min2_r <= '0;
    end else if (ctl_i.update) begin
      max1_r <= max1_nxt;
      max2_r <= max2_nxt;
      min1_r <= min1_nxt;
      min2_r <= min2_nxt;
    end
  end

  // The result carries the extremes with its own sample already included.
  assign ext_o = {max1_nxt, max2_nxt, min1_nxt, min2_nxt};

endmodule

// ===== src/afce_result_pipe.sv =====
// Result pipeline: magnitude, reciprocal multiply, rounding correction and
// saturation of the volts value, with the sample and extremes carried alongside.
// Depends on afce_pkg and afce_out_if.
module afce_result_pipe #(
  parameter int SAMPLE_BITS = afce_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [4*SAMPLE_BITS-1:0]      ext_i,
  output logic                          in_ready_o,
  afce_out_if.source                    out_ch
);

  localparam int SB    = SAMPLE_BITS;
  localparam int EXT_W = 4 * SAMPLE_BITS;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic st1_rdy, st2_rdy, st3_rdy, st4_rdy, st5_rdy;

  logic signed [SB-1:0] smp1_r, smp2_r, smp3_r, smp4_r, smp5_r;
  logic [EXT_W-1:0]     ext1_r, ext2_r, ext3_r, ext4_r, ext5_r;
  logic                 neg2_r, neg3_r, neg4_r;
  logic [afce_pkg::MAG_W-1:0] mag2_r, mag3_r;
  logic [afce_pkg::Q_W-1:0]   qe3_r, q4_r;
  logic signed [afce_pkg::VOLTS_W-1:0] volts5_r;

  // Each stage moves on when the one after it is empty or moving.
  assign st5_rdy    = !v5_r || out_ch.ready;
  assign st4_rdy    = !v4_r || st5_rdy;
  assign st3_rdy    = !v3_r || st4_rdy;
  assign st2_rdy    = !v2_r || st3_rdy;
  assign st1_rdy    = !v1_r || st2_rdy;
  assign in_ready_o = st1_rdy;

  // Stage 2: magnitude of the sample, clipped where the result saturates anyway.
  logic signed [31:0]         s32;
  logic [31:0]                abs32;
  logic [afce_pkg::MAG_W-1:0] mag_c;

  assign s32   = 32'(smp1_r);
  assign abs32 = smp1_r[SB-1] ? 32'(-s32) : 32'(s32);
  assign mag_c = (abs32 > 32'(afce_pkg::VOLT_CLAMP)) ? afce_pkg::VOLT_CLAMP
                                                     : abs32[afce_pkg::MAG_W-1:0];

  // Stage 3: quotient estimate, at most one below the rounded quotient.
  logic [afce_pkg::PROD_W-1:0] prod;
  logic [afce_pkg::SUM_W-1:0]  sum;

  assign prod = afce_pkg::PROD_W'(mag2_r) * afce_pkg::PROD_W'(afce_pkg::RECIP);
  assign sum  = {prod, 10'd0} + afce_pkg::ROUND_TERM;

  // Stage 4: correct the estimate by checking the remainder.
  logic [afce_pkg::Y_W-1:0]   y;
  logic [afce_pkg::REM_W-1:0] qd, rem;
  logic [afce_pkg::Q_W-1:0]   q_c;

  assign y   = {mag3_r, 10'd0} + afce_pkg::Y_W'(afce_pkg::ROUND_BIAS);
  assign qd  = afce_pkg::REM_W'(qe3_r) * afce_pkg::REM_W'(afce_pkg::VOLT_DIV);
  assign rem = afce_pkg::REM_W'(y) - qd;
  assign q_c = (rem >= afce_pkg::REM_W'(afce_pkg::VOLT_DIV)) ? qe3_r + 1'b1 : qe3_r;

  // Stage 5: apply the sign and saturate.
  logic signed [afce_pkg::VOLTS_W-1:0] volts_c;

  always_comb begin
    if (neg4_r) begin
      volts_c = (q4_r > afce_pkg::VOLTS_NEG_MAG) ? afce_pkg::VOLTS_W'(-afce_pkg::VOLTS_NEG_MAG)
                                                 : afce_pkg::VOLTS_W'(-q4_r);
    end else begin
      volts_c = (q4_r > afce_pkg::VOLTS_POS_MAX) ? afce_pkg::VOLTS_POS_MAX : q4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (st1_rdy) v1_r <= push_i;
      if (st2_rdy) v2_r <= v1_r;
      if (st3_rdy) v3_r <= v2_r;
      if (st4_rdy) v4_r <= v3_r;
      if (st5_rdy) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_rdy) begin
      smp1_r <= sample_i;
      ext1_r <= ext_i;
    end
    if (st2_rdy) begin
      smp2_r <= smp1_r;
      ext2_r <= ext1_r;
      neg2_r <= smp1_r[SB-1];
      mag2_r <= mag_c;
    end
    if (st3_rdy) begin
      smp3_r <= smp2_r;
      ext3_r <= ext2_r;
      neg3_r <= neg2_r;
      mag3_r <= mag2_r;
      qe3_r  <= sum[afce_pkg::RECIP_SHIFT +: afce_pkg::Q_W];
    end
    if (st4_rdy) begin
      smp4_r <= smp3_r;
      ext4_r <= ext3_r;
      neg4_r <= neg3_r;
      q4_r   <= q_c;
    end
    if (st5_rdy) begin
      smp5_r   <= smp4_r;
      ext5_r   <= ext4_r;
      volts5_r <= volts_c;
    end
  end

  // Result fields are the low bits of the 32-bit sign-extended values.
  logic signed [SB-1:0] o_max1, o_max2, o_min1, o_min2;
  logic signed [31:0]   w_smp, w_max1, w_max2, w_min1, w_min2;

  assign o_max1 = ext5_r[4*SB-1 -: SB];
  assign o_max2 = ext5_r[3*SB-1 -: SB];
  assign o_min1 = ext5_r[2*SB-1 -: SB];
  assign o_min2 = ext5_r[SB-1 -: SB];
  assign w_smp  = 32'(smp5_r);
  assign w_max1 = 32'(o_max1);
  assign w_max2 = 32'(o_max2);
  assign w_min1 = 32'(o_min1);
  assign w_min2 = 32'(o_min2);

  assign out_ch.valid            = v5_r;
  assign out_ch.sample_raw       = w_smp[afce_pkg::RAW_W-1:0];
  assign out_ch.sample_volts_q16 = volts5_r;
  assign out_ch.max_first        = w_max1[afce_pkg::MAX_W-1:0];
  assign out_ch.max_second       = w_max2[afce_pkg::MAX_W-1:0];
  assign out_ch.min_first        = w_min1[afce_pkg::MIN_W-1:0];
  assign out_ch.min_second       = w_min2[afce_pkg::MIN_W-1:0];

endmodule

// ===== src/adc_frame_channel_extremes.sv =====
// Each result enters stage 1 with its word and reaches out_ch from stage 5.
// Throughput: one word per cycle, set by the five-stage volts pipeline; a stage
// holds only when it is full and the stage after it holds, so the input stalls
// only once all five stages are full and the output is blocked.
// Reset (rst_n, synchronous): parser hunts for sync, extremes are zero, the
// pipeline is empty, channel_id = 234 and max_frame_bytes = 1500.
module adc_frame_channel_extremes #(
  parameter int SAMPLE_BITS = afce_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  afce_in_if.sink                           in_ch,
  afce_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [afce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afce_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [7:0]  channel_id_r;
  logic [11:0] max_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_id_r <= afce_pkg::CHANNEL_ID_RST;
      max_frame_r  <= afce_pkg::MAX_FRAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afce_pkg::CFG_CHANNEL_ID: channel_id_r <= cfg_wdata[7:0];
        afce_pkg::CFG_MAX_FRAME:  max_frame_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic                          pipe_ready;
  logic                          in_fire;
  logic                          hit;
  logic                          push;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [4*SAMPLE_BITS-1:0]      ext_nxt;
  afce_pkg::afce_track_ctl_t     track_ctl;

  assign in_ch.ready = pipe_ready;
  assign in_fire     = in_ch.valid && pipe_ready;
  assign push        = in_fire && hit;
  assign sample      = in_ch.data_word[SAMPLE_BITS-1:0];

  assign track_ctl.clear  = in_fire && in_ch.command;
  assign track_ctl.update = push;

  afce_frame_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire_i       (in_fire),
    .command_i    (in_ch.command),
    .data_word_i  (in_ch.data_word),
    .channel_id_i (channel_id_r),
    .max_frame_i  (max_frame_r),
    .hit_o        (hit)
  );

  afce_extremes #(.SAMPLE_BITS(SAMPLE_BITS)) u_extremes (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (track_ctl),
    .sample_i (sample),
    .ext_o    (ext_nxt)
  );

  afce_result_pipe #(.SAMPLE_BITS(SAMPLE_BITS)) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .sample_i   (sample),
    .ext_i      (ext_nxt),
    .in_ready_o (pipe_ready),
    .out_ch     (out_ch)
  );

`ifndef NO_ASSERTIONS
  logic signed [SAMPLE_BITS-1:0] a_max1, a_max2, a_min1, a_min2;
  assign a_max1 = ext_nxt[4*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign a_max2 = ext_nxt[3*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign a_min1 = ext_nxt[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign a_min2 = ext_nxt[SAMPLE_BITS-1 -: SAMPLE_BITS];

  // The second extremes never pass the first ones.
  a_extreme_order: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (a_max1 >= a_max2) && (a_min1 <= a_min2))
    else $error("extremes out of order");

  // The input stalls only when every stage is full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  // A clear command never produces a result word.
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.command) |-> !push)
    else $error("clear command produced a result");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for adc_frame_channel_extremes: directed frames from a table, then random traffic.
// Every result word is checked against a built-in deframer and extremes tracker.
// Depends on afce_pkg, afce_in_if, afce_out_if and the block itself.
module tb;

  localparam int     SMP_BITS     = afce_pkg::SAMPLE_BITS_DEF;
  localparam longint SAMPLE_SPAN  = longint'(1) << SMP_BITS;
  localparam longint VOLT_SCALE   = 10 * 65536;
  localparam longint VOLT_DEN     = 6000000;
  localparam longint VOLTS_HI     = 1048575;
  localparam longint VOLTS_LO     = -1048576;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     LONG_STALL   = 400;

  typedef enum logic [1:0] {SEEK_SYNC, SEEK_HEADER, SEEK_COUNT, IN_PAYLOAD} parse_phase_t;

  typedef struct packed {
    logic signed [afce_pkg::RAW_W-1:0]   raw;
    logic signed [afce_pkg::VOLTS_W-1:0] volts;
    logic        [afce_pkg::MAX_W-1:0]   max1;
    logic        [afce_pkg::MAX_W-1:0]   max2;
    logic signed [afce_pkg::MIN_W-1:0]   min1;
    logic signed [afce_pkg::MIN_W-1:0]   min2;
  } sample_rec_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] word;
    logic        zero_sample;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [afce_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [afce_pkg::CFG_DATA_W-1:0] cfg_wdata;

  afce_in_if  in_ch();
  afce_out_if out_ch();

  adc_frame_channel_extremes u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's parser, extremes and registers.
  parse_phase_t frame_phase;
  logic [9:0]   words_left;
  int           top_max, next_max, top_min, next_min;
  logic [7:0]   chan_id;
  logic [11:0]  max_bytes;

  sample_rec_t expected_samples[$];
  int          fail_count = 0;
  int          live_words = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  bit          long_stall_req = 1'b0;

  // Bad header, oversized, empty frame, other channel, repeated extreme, clear mid-stream.
  stim_row_t directed_rows [25] = '{
    '{1'b0, 32'h1234_5678, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 1'b0},
    '{1'b0, 32'h0000_000C, 1'b0},
    '{1'b0, 32'hEA00_0000, 1'b1},
    '{1'b0, 32'hEA7F_FFFF, 1'b0},
    '{1'b0, 32'h1180_0000, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'h8000_0000, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0003, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_05DD, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0008, 1'b0},
    '{1'b0, 32'hEA80_0000, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0008, 1'b0},
    '{1'b0, 32'hEA80_0000, 1'b0},
    '{1'b0, 32'hEA80_0000, 1'b0}
  };

  function automatic void clear_tracker();
    frame_phase = SEEK_SYNC;
    words_left  = '0;
    top_max     = 0;
    next_max    = 0;
    top_min     = 0;
    next_min    = 0;
  endfunction

  task automatic deframe_word(input logic cmd, input logic [31:0] w,
                              output bit got, output sample_rec_t rec);
    longint v;
    longint num;
    longint q;
    int     s;
    got = 1'b0;
    rec = '0;
    if (cmd) begin
      clear_tracker();
      return;
    end
    case (frame_phase)
      SEEK_SYNC: begin
        if (w == afce_pkg::SYNC_WORD) frame_phase = SEEK_HEADER;
      end
      SEEK_HEADER: begin
        frame_phase = w[31] ? SEEK_SYNC : SEEK_COUNT;
      end
      SEEK_COUNT: begin
        if (w > max_bytes || w[31:2] == 0) begin
          frame_phase = SEEK_SYNC;
          words_left  = '0;
        end else begin
          words_left  = w[11:2];
          frame_phase = IN_PAYLOAD;
        end
      end
      default: begin
        if (words_left != 0) words_left = words_left - 1'b1;
        if (words_left == 0) frame_phase = SEEK_SYNC;
        got = (w[31:24] == chan_id);
      end
    endcase
    if (!got) return;

    v = longint'(w) & (SAMPLE_SPAN - 1);
    if (v >= SAMPLE_SPAN / 2) v = v - SAMPLE_SPAN;
    s = int'(v);

    // Round half away from zero, then saturate to the volts field.
    num = longint'(s) * VOLT_SCALE;
    if (num >= 0) q = (num + VOLT_DEN / 2) / VOLT_DEN;
    else q = -((-num + VOLT_DEN / 2) / VOLT_DEN);
    if (q > VOLTS_HI) q = VOLTS_HI;
    if (q < VOLTS_LO) q = VOLTS_LO;

    if (s > top_max) begin
      next_max = top_max;
      top_max  = s;
    end else if (s < top_max && s > next_max) begin
      next_max = s;
    end
    if (s < top_min) begin
      next_min = top_min;
      top_min  = s;
    end else if (s > top_min && s < next_min) begin
      next_min = s;
    end

    rec.raw   = s[afce_pkg::RAW_W-1:0];
    rec.volts = q[afce_pkg::VOLTS_W-1:0];
    rec.max1  = top_max[afce_pkg::MAX_W-1:0];
    rec.max2  = next_max[afce_pkg::MAX_W-1:0];
    rec.min1  = top_min[afce_pkg::MIN_W-1:0];
    rec.min2  = next_min[afce_pkg::MIN_W-1:0];
  endtask

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Offers one word, waits for it to be taken and records the sample it should produce.
  task automatic send_word(input logic cmd, input logic [31:0] w, input bit zero_sample = 1'b0);
    bit          got;
    sample_rec_t rec;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_word <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd || frame_phase != SEEK_SYNC || w == afce_pkg::SYNC_WORD) live_words++;
    deframe_word(cmd, w, got, rec);
    if (got) expected_samples.push_back(zero_sample ? sample_rec_t'('0) : rec);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The upper data bits are random so that the channel id write must mask them.
  task automatic set_config(input logic [7:0] chan, input logic [11:0] maxb);
    cfg_we    <= 1'b1;
    cfg_index <= afce_pkg::CFG_CHANNEL_ID;
    cfg_wdata <= {4'($urandom), chan};
    @(posedge clk);
    cfg_index <= afce_pkg::CFG_MAX_FRAME;
    cfg_wdata <= maxb;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chan_id   = chan;
    max_bytes = maxb;
  endtask

  // Mostly well-formed frames with random content, the rest clears, bad headers and stray words.
  task automatic run_random(input int target);
    int          start_count;
    int          pick;
    int unsigned count;
    int unsigned n;
    logic [23:0] smp;
    logic [7:0]  tag;
    start_count = live_words;
    while (live_words - start_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_word(1'b0, afce_pkg::SYNC_WORD);
        send_word(1'b0, $urandom & 32'h7FFF_FFFF);
        pick = $urandom_range(0, 99);
        if (pick < 75) count = $urandom_range(4, 64);
        else if (pick < 78) count = $urandom_range(0, max_bytes);
        else if (pick < 81) count = max_bytes;
        else if (pick < 89) count = $urandom_range(0, 3);
        else if (pick < 95) count = max_bytes + $urandom_range(1, 8);
        else count = $urandom;
        send_word(1'b0, count);
        n = (count <= max_bytes && count >= 4) ? count >> 2 : 0;
        // A few frames are cut short or run over.
        if ($urandom_range(0, 99) < 5) n = $urandom_range(0, n + 2);
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            case ($urandom_range(0, 5))
              0:       smp = 24'h00_0000;
              1:       smp = 24'h00_0001;
              2:       smp = 24'hFF_FFFF;
              3:       smp = 24'h7F_FFFF;
              4:       smp = 24'h80_0000;
              default: smp = 24'h80_0001;
            endcase
          end else if (pick < 45) begin
            smp = 24'($urandom_range(0, 400)) - 24'd200;
          end else begin
            smp = 24'($urandom);
          end
          tag = ($urandom_range(0, 99) < 75) ? chan_id : 8'($urandom);
          send_word(1'b0, {tag, smp});
        end
      end else if (pick < 85) begin
        send_word(1'b1, $urandom);
      end else if (pick < 92) begin
        send_word(1'b0, afce_pkg::SYNC_WORD);
        send_word(1'b0, 32'h8000_0000 | $urandom);
      end else begin
        send_word(1'b0, $urandom);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : result_side
    int          stall_left;
    sample_rec_t want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $error("result word arrived with no sample expected");
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          check_field("sample_raw", want.raw, out_ch.sample_raw);
          check_field("sample_volts_q16", want.volts, out_ch.sample_volts_q16);
          check_field("max_first", want.max1, out_ch.max_first);
          check_field("max_second", want.max2, out_ch.max_second);
          check_field("min_first", want.min1, out_ch.min_first);
          check_field("min_second", want.min2, out_ch.min_second);
        end
      end
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= afce_pkg::CFG_CHANNEL_ID;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= 1'b0;
    in_ch.data_word <= '0;
    chan_id   = afce_pkg::CHANNEL_ID_RST;
    max_bytes = afce_pkg::MAX_FRAME_RST;
    clear_tracker();
    in_idle_pct  = 15;
    out_idle_pct = 49;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].cmd, directed_rows[i].word, directed_rows[i].zero_sample);
    settle();

    set_config(8'd0, 12'd4095);
    run_random(350);
    settle();

    in_idle_pct  = 49;
    out_idle_pct = 15;
    set_config(8'd255, 12'd0);
    run_random(100);
    settle();

    // The receiver holds off for a long stretch while words keep coming.
    set_config(8'($urandom), 12'($urandom_range(4, 300)));
    run_random(150);
    long_stall_req = 1'b1;
    run_random(200);
    settle();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_config(afce_pkg::CHANNEL_ID_RST, 12'd64);
    run_random(200);
    settle();
    run_random(200);
    settle();

    if (fail_count == 0) begin
      $display("adc_frame_channel_extremes test passed");
    end else begin
      $display("adc_frame_channel_extremes test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("adc_frame_channel_extremes test failed");
    $finish;
  end

endmodule
